/* rtl/core/trlc_pkg.sv */
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared types and constants for the reduction layout classifier.
// ----------------------------------------------------------------------------
package trlc_pkg;

    localparam int MAX_RANK = 8;
    localparam int DIM_W    = 32;
    localparam int PROD_W   = 63;
    // position counter saturates at MAX_RANK + 1
    localparam int POS_W    = $clog2(MAX_RANK + 2);
    localparam int TDATA_W  = ((5 * PROD_W + 7) / 8) * 8;
    localparam int TUSER_W  = 3;

    localparam logic [PROD_W-1:0] SAT_MAX = {PROD_W{1'b1}};
    localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(1);

    typedef enum logic [1:0] {
        PATH_GENERIC = 2'd0,
        PATH_INNER   = 2'd1,
        PATH_OUTER   = 2'd2
    } t_path;

    // Layout flags captured with the final dimension
    typedef struct packed {
        logic rank_err;
        logic contig;
        logic seen_red;
        logic ends_red;
        logic not_consec;
        logic first_zero;
    } t_flags;

endpackage

/* rtl/core/tensor_reduction_layout_classifier_unit.sv */
// ----------------------------------------------------------------------------
// tensor_reduction_layout_classifier_unit
// Classifies a reduction over a row-major tensor from its dimension stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per tensor dimension, outermost first.
//     tdata = dim_size, tuser = {contiguous, reduced}, tlast marks the
//     innermost dimension (contiguous is only looked at with tlast).
//   Master channel: one item per tensor, issued for the tlast item, carrying
//     the access path, element counts and strides.
//   Throughput: one dimension item per cycle while o_s_tready is high. The
//     running products are updated by one 63x32 saturating multiply (two 32-bit
//     partial products) in the accept cycle, so dimensions may come back to back.
//   Pipeline: three register stages (snapshot, partial products,
//     combine/classify); the first loads at the edge that accepts the tlast
//     item and o_m_tvalid is driven from the third stage's valid flag.
//   Reset: i_rst_n low clears the running state and empties the result
//     pipeline; the first item after reset is the outermost dimension.
//   Stall: while i_m_tready is low, occupied result stages hold unless the
//     next one is empty; o_s_tready drops only once all three are occupied.
// ----------------------------------------------------------------------------
module tensor_reduction_layout_classifier_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [trlc_pkg::DIM_W-1:0]   i_s_tdata,   // [31:0] dim_size
    input  logic [1:0]                   i_s_tuser,   // [0] reduced, [1] contiguous
    input  logic                         i_s_tlast,   // last
    // master side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [trlc_pkg::TDATA_W-1:0] o_m_tdata,   // output count, reduce count,
                                                      // inner count, row stride,
                                                      // outer stride (63b each), pad
    output logic [trlc_pkg::TUSER_W-1:0] o_m_tuser    // [1:0] path, [2] rank_error
);
    import trlc_pkg::*;

    // ---------------- running state ----------------
    logic [POS_W-1:0]  r_pos;
    logic [PROD_W-1:0] r_before, r_red, r_after;
    logic              r_seen, r_gap, r_nc, r_first_zero;

    logic [POS_W-1:0]  n_pos;
    logic [PROD_W-1:0] n_before, n_red, n_after;
    logic              n_seen, n_gap, n_nc, n_first_zero, n_rank_err;
    logic [PROD_W-1:0] w_sel, w_prod;
    logic              w_red, w_acc;

    // ---------------- result stages ----------------
    logic              r_a_valid, r_b_valid, r_c_valid;
    logic              w_rdy_a, w_rdy_b, w_rdy_c;
    t_flags            r_a_flags, r_b_flags;
    logic [PROD_W-1:0] r_a_before, r_a_red, r_a_after;
    logic [PROD_W-1:0] r_b_before, r_b_red, r_b_after;
    // partial products of before*after (ba) and reduced*after (ra)
    logic [63:0]       r_ba_ll, r_ra_ll;
    logic [62:0]       r_ba_lh, r_ba_hl, r_ra_lh, r_ra_hl;
    logic [61:0]       r_ba_hh, r_ra_hh;
    logic [PROD_W-1:0] w_ba, w_ra;
    t_path             w_path;
    logic [PROD_W-1:0] w_nout, w_rcount, w_icount, w_rstride, w_ostride;
    logic [TDATA_W-1:0] r_m_tdata;
    logic [TUSER_W-1:0] r_m_tuser;

    function automatic logic [PROD_W-1:0] f_sat_mul_dim(
        input logic [PROD_W-1:0] a,
        input logic [DIM_W-1:0]  d
    );
        logic [63:0] p_lo;
        logic [62:0] p_hi;
        logic [94:0] p;
        p_lo = 64'(a[31:0]) * 64'(d);
        p_hi = 63'(a[62:32]) * 63'(d);
        p    = {p_hi, 32'd0} + {31'd0, p_lo};
        return (p[94:63] != 32'd0) ? SAT_MAX : p[62:0];
    endfunction

    function automatic logic [PROD_W-1:0] f_sat_combine(
        input logic [63:0] ll,
        input logic [62:0] lh,
        input logic [62:0] hl,
        input logic [61:0] hh
    );
        logic [125:0] s;
        s = {hh, 64'd0} + {31'd0, lh, 32'd0} + {31'd0, hl, 32'd0} + {62'd0, ll};
        return (s[125:63] != 63'd0) ? SAT_MAX : s[62:0];
    endfunction

    assign w_rdy_c    = !r_c_valid || i_m_tready;
    assign w_rdy_b    = !r_b_valid || w_rdy_c;
    assign w_rdy_a    = !r_a_valid || w_rdy_b;
    assign o_s_tready = w_rdy_a;
    assign w_acc      = i_s_tvalid && w_rdy_a;
    assign w_red      = i_s_tuser[0];

    // Per-dimension update. With no reduced axis seen, the before product
    // equals the product of all dimensions, so no separate total is kept.
    always_comb begin
        n_before     = r_before;
        n_red        = r_red;
        n_after      = r_after;
        n_seen       = r_seen;
        n_gap        = r_gap;
        n_nc         = r_nc;
        n_first_zero = r_first_zero;
        w_sel        = w_red ? r_red : (r_seen ? r_after : r_before);
        w_prod       = f_sat_mul_dim(w_sel, i_s_tdata);
        if (w_red) begin
            if (!r_seen) begin
                n_seen       = 1'b1;
                n_first_zero = (r_pos == '0);
            end else if (r_gap) begin
                n_nc = 1'b1;
            end
            n_red = w_prod;
        end else if (r_seen) begin
            n_gap   = 1'b1;
            n_after = w_prod;
        end else begin
            n_before = w_prod;
        end
        n_pos      = (r_pos <= POS_W'(MAX_RANK)) ? r_pos + POS_W'(1) : r_pos;
        n_rank_err = (n_pos > POS_W'(MAX_RANK));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_before     <= PROD_ONE;
            r_red        <= PROD_ONE;
            r_after      <= PROD_ONE;
            r_seen       <= 1'b0;
            r_gap        <= 1'b0;
            r_nc         <= 1'b0;
            r_first_zero <= 1'b0;
        end else if (w_acc) begin
            if (i_s_tlast) begin
                r_pos        <= '0;
                r_before     <= PROD_ONE;
                r_red        <= PROD_ONE;
                r_after      <= PROD_ONE;
                r_seen       <= 1'b0;
                r_gap        <= 1'b0;
                r_nc         <= 1'b0;
                r_first_zero <= 1'b0;
            end else begin
                r_pos        <= n_pos;
                r_before     <= n_before;
                r_red        <= n_red;
                r_after      <= n_after;
                r_seen       <= n_seen;
                r_gap        <= n_gap;
                r_nc         <= n_nc;
                r_first_zero <= n_first_zero;
            end
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= w_acc && i_s_tlast;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage A: snapshot of the finished tensor
    always_ff @(posedge i_clk) begin
        if (w_acc && i_s_tlast) begin
            r_a_flags.rank_err   <= n_rank_err;
            r_a_flags.contig     <= i_s_tuser[1];
            r_a_flags.seen_red   <= n_seen;
            r_a_flags.ends_red   <= w_red;
            r_a_flags.not_consec <= n_nc;
            r_a_flags.first_zero <= n_first_zero;
            r_a_before           <= n_before;
            r_a_red              <= n_red;
            r_a_after            <= n_after;
        end
    end

    // Stage B: 32-bit partial products for the two final multiplies
    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_a_valid) begin
            r_b_flags  <= r_a_flags;
            r_b_before <= r_a_before;
            r_b_red    <= r_a_red;
            r_b_after  <= r_a_after;
            r_ba_ll    <= 64'(r_a_before[31:0])  * 64'(r_a_after[31:0]);
            r_ba_lh    <= 63'(r_a_before[31:0])  * 63'(r_a_after[62:32]);
            r_ba_hl    <= 63'(r_a_before[62:32]) * 63'(r_a_after[31:0]);
            r_ba_hh    <= 62'(r_a_before[62:32]) * 62'(r_a_after[62:32]);
            r_ra_ll    <= 64'(r_a_red[31:0])     * 64'(r_a_after[31:0]);
            r_ra_lh    <= 63'(r_a_red[31:0])     * 63'(r_a_after[62:32]);
            r_ra_hl    <= 63'(r_a_red[62:32])    * 63'(r_a_after[31:0]);
            r_ra_hh    <= 62'(r_a_red[62:32])    * 62'(r_a_after[62:32]);
        end
    end

    // Stage C: combine products and classify
    always_comb begin
        w_ba      = f_sat_combine(r_ba_ll, r_ba_lh, r_ba_hl, r_ba_hh);
        w_ra      = f_sat_combine(r_ra_ll, r_ra_lh, r_ra_hl, r_ra_hh);
        w_path    = PATH_GENERIC;
        w_nout    = '0;
        w_rcount  = '0;
        w_icount  = '0;
        w_rstride = '0;
        w_ostride = '0;
        if (!r_b_flags.rank_err && r_b_flags.contig) begin
            if (!r_b_flags.seen_red) begin
                // nothing flagged: reduce over everything
                w_path    = PATH_INNER;
                w_nout    = PROD_ONE;
                w_rcount  = r_b_before;
                w_ostride = r_b_before;
            end else if (!r_b_flags.not_consec) begin
                if (r_b_flags.ends_red) begin
                    w_path    = PATH_INNER;
                    w_nout    = r_b_before;
                    w_rcount  = r_b_red;
                    w_ostride = r_b_red;
                end else if (r_b_flags.first_zero ||
                             (r_b_after != PROD_ONE && r_b_before == PROD_ONE)) begin
                    w_path    = PATH_OUTER;
                    w_nout    = r_b_after;
                    w_rcount  = r_b_red;
                    w_icount  = r_b_after;
                    w_rstride = r_b_after;
                    w_ostride = r_b_after;
                end else if (r_b_after == PROD_ONE) begin
                    w_path    = PATH_INNER;
                    w_nout    = r_b_before;
                    w_rcount  = r_b_red;
                    w_ostride = r_b_red;
                end else begin
                    w_path    = PATH_OUTER;
                    w_nout    = w_ba;
                    w_rcount  = r_b_red;
                    w_icount  = r_b_after;
                    w_rstride = r_b_after;
                    w_ostride = w_ra;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_b_valid) begin
            r_m_tdata <= {(TDATA_W - 5 * PROD_W)'(0), w_ostride, w_rstride,
                          w_icount, w_rcount, w_nout};
            r_m_tuser <= {r_b_flags.rank_err, w_path};
        end
    end

    assign o_m_tvalid = r_c_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // ---------------- checks ----------------
    a_generic_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1:0] == PATH_GENERIC) |-> (o_m_tdata == '0))
        else $error("generic path result carries nonzero counts");

    a_rank_generic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == PATH_GENERIC))
        else $error("rank error without generic path");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tlast) |=> (r_pos == '0 && r_before == PROD_ONE &&
                                  r_red == PROD_ONE && !r_seen))
        else $error("running state not cleared after final dimension");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_RANK + 1))
        else $error("dimension counter beyond saturation");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && w_rdy_c) |=> r_c_valid)
        else $error("result lost between classify stage and output");

endmodule

/* tb/sv/tensor_reduction_layout_classifier_unit_tb.sv */
// ----------------------------------------------------------------------------
// tensor_reduction_layout_classifier_unit_tb
// Streams tensor shapes into the layout classifier and checks every result
// item against a cycle-free model of the classification. The sender runs in
// random bursts, the receiver stalls in changing patterns. Stimulus opens
// with one shape per layout case, then random shapes, mostly with a single
// reduced block, some with scattered flags, too many dims or no contiguity.
// ----------------------------------------------------------------------------
module tensor_reduction_layout_classifier_unit_tb;

    import trlc_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0] size;
        logic             reduced;
        logic             last;
        logic             contig;
    } t_dim;

    typedef struct packed {
        t_path             path;
        logic [PROD_W-1:0] outputs;
        logic [PROD_W-1:0] red_count;
        logic [PROD_W-1:0] inner;
        logic [PROD_W-1:0] row_stride;
        logic [PROD_W-1:0] outer_stride;
        logic              rank_err;
    } t_layout;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [DIM_W-1:0]    i_s_tdata = '0;    // [31:0] dim_size
    logic [1:0]          i_s_tuser = '0;    // [0] reduced, [1] contiguous
    logic                i_s_tlast = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [TDATA_W-1:0]  o_m_tdata;         // output count, reduce count, inner count,
                                            // row stride, outer stride, pad
    logic [TUSER_W-1:0]  o_m_tuser;         // [1:0] path, [2] rank_error

    tensor_reduction_layout_classifier_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    t_dim    dims_pending[$];
    t_layout expected_layouts[$];
    int      mismatches = 0;

    // running shape state
    logic [POS_W-1:0]  dims_seen;
    logic [PROD_W-1:0] prod_lead, prod_red, prod_trail, prod_all;
    logic [POS_W-1:0]  red_start;
    logic              red_seen, red_gap, red_split, prev_red;

    function automatic logic [PROD_W-1:0] clamp_product(logic [PROD_W-1:0] a,
                                                        logic [PROD_W-1:0] b);
        logic [2*PROD_W-1:0] full;
        full = (2*PROD_W)'(a) * (2*PROD_W)'(b);
        if (full > {{PROD_W{1'b0}}, SAT_MAX})
            return SAT_MAX;
        return full[PROD_W-1:0];
    endfunction

    task automatic clear_shape();
        dims_seen  = '0;
        prod_lead  = PROD_ONE;
        prod_red   = PROD_ONE;
        prod_trail = PROD_ONE;
        prod_all   = PROD_ONE;
        red_start  = '0;
        red_seen   = 1'b0;
        red_gap    = 1'b0;
        red_split  = 1'b0;
        prev_red   = 1'b0;
    endtask

    // Fold one accepted dim into the shape; on the last dim queue the layout.
    task automatic track_dimension(t_dim d);
        logic [PROD_W-1:0] sz;
        t_layout           res;
        sz = PROD_W'(d.size);
        prod_all = clamp_product(prod_all, sz);
        if (d.reduced) begin
            if (!red_seen) begin
                red_start = dims_seen;
                red_seen  = 1'b1;
            end else if (red_gap) begin
                red_split = 1'b1;
            end
            prod_red = clamp_product(prod_red, sz);
        end else if (red_seen) begin
            red_gap    = 1'b1;
            prod_trail = clamp_product(prod_trail, sz);
        end else begin
            prod_lead = clamp_product(prod_lead, sz);
        end
        prev_red = d.reduced;
        if (dims_seen <= MAX_RANK)
            dims_seen = dims_seen + 1'b1;
        if (!d.last)
            return;

        res = '0;
        res.path = PATH_GENERIC;
        res.rank_err = (dims_seen > MAX_RANK);
        if (!res.rank_err && d.contig) begin
            if (!red_seen) begin
                // nothing flagged: reduce everything
                res.path         = PATH_INNER;
                res.outputs      = PROD_ONE;
                res.red_count    = prod_all;
                res.outer_stride = prod_all;
            end else if (!red_split) begin
                if (!prev_red && (red_start == 0 ||
                                  (prod_trail != PROD_ONE && prod_lead == PROD_ONE))) begin
                    res.path         = PATH_OUTER;
                    res.outputs      = prod_trail;
                    res.red_count    = prod_red;
                    res.inner        = prod_trail;
                    res.row_stride   = prod_trail;
                    res.outer_stride = prod_trail;
                end else if (prev_red || prod_trail == PROD_ONE) begin
                    res.path         = PATH_INNER;
                    res.outputs      = prod_lead;
                    res.red_count    = prod_red;
                    res.outer_stride = prod_red;
                end else begin
                    res.path         = PATH_OUTER;
                    res.outputs      = clamp_product(prod_lead, prod_trail);
                    res.red_count    = prod_red;
                    res.inner        = prod_trail;
                    res.row_stride   = prod_trail;
                    res.outer_stride = clamp_product(prod_red, prod_trail);
                end
            end
        end
        expected_layouts.insert(expected_layouts.size(), res);
        clear_shape();
    endtask

    task automatic add_dim(logic [DIM_W-1:0] size, bit red, bit last, bit contig);
        t_dim d;
        d.size    = size;
        d.reduced = red;
        d.last    = last;
        d.contig  = contig;
        dims_pending.insert(dims_pending.size(), d);
    endtask

    // mostly small sizes with many ones, some zeros and some full-range values
    function automatic logic [DIM_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel <= 5)
            return 32'd1;
        if (sel <= 14)
            return $urandom_range(2, 16);
        if (sel <= 17)
            return $urandom_range(17, 65535);
        return $urandom;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [PROD_W-1:0] got, logic [PROD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%h want 0x%h", name, got, want));
    endtask

    // ---------------- sender ----------------
    t_dim cur_dim;
    int   burst_left = 1;
    int   gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                track_dimension(cur_dim);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0 || dims_pending.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_s_tvalid <= 1'b0;
                end else begin
                    cur_dim = dims_pending.pop_front();
                    i_s_tdata  <= cur_dim.size;
                    i_s_tuser  <= {cur_dim.contig, cur_dim.reduced};
                    i_s_tlast  <= cur_dim.last;
                    i_s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    // ---------------- receiver ----------------
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(32, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    // long stalls now and then
                    if (rx_stall_left > 0) begin
                        rx_stall_left--;
                        i_m_tready <= 1'b0;
                    end else begin
                        if ($urandom_range(0, 5) == 0)
                            rx_stall_left = $urandom_range(1, 24);
                        i_m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : monitor
        t_layout want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_layouts.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = expected_layouts.pop_front();
                check_field("path", PROD_W'(o_m_tuser[1:0]), PROD_W'(want.path));
                check_field("output_count", o_m_tdata[0*PROD_W +: PROD_W], want.outputs);
                check_field("reduce_count", o_m_tdata[1*PROD_W +: PROD_W], want.red_count);
                check_field("inner_elems", o_m_tdata[2*PROD_W +: PROD_W], want.inner);
                check_field("row_stride", o_m_tdata[3*PROD_W +: PROD_W], want.row_stride);
                check_field("outer_stride", o_m_tdata[4*PROD_W +: PROD_W], want.outer_stride);
                check_field("rank_error", PROD_W'(o_m_tuser[2]), PROD_W'(want.rank_err));
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int rank, len, start, kind;
        bit contig;
        bit [MAX_RANK+3:0] flags;

        clear_shape();

        // directed shapes
        add_dim(32'd0, 0, 1, 1);                                  // nothing flagged, zero size
        add_dim(32'd3, 0, 0, 1); add_dim(32'd4, 1, 1, 1);         // block at the end
        add_dim(32'd4, 1, 0, 1); add_dim(32'd3, 0, 1, 1);         // block at the front
        add_dim(32'hFFFF_FFFF, 0, 0, 0);                          // middle block, full-range sizes
        add_dim(32'hFFFF_FFFF, 1, 0, 0);
        add_dim(32'd3, 0, 1, 1);
        add_dim(32'd1, 0, 0, 1); add_dim(32'd3, 1, 0, 1);         // nothing before the block
        add_dim(32'd5, 0, 1, 1);
        add_dim(32'd2, 0, 0, 1); add_dim(32'd3, 1, 0, 1);         // nothing after the block
        add_dim(32'd1, 0, 1, 1);
        add_dim(32'd2, 1, 0, 1); add_dim(32'd3, 0, 0, 1);         // split reduced axes
        add_dim(32'd4, 1, 1, 1);
        add_dim(32'd7, 0, 0, 1); add_dim(32'd5, 1, 1, 0);         // not contiguous
        for (int i = 0; i <= MAX_RANK; i++)                       // one dim too many
            add_dim(32'd2, i[0], i == MAX_RANK, 1);

        // random shapes
        while (dims_pending.size() < 1750) begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
                rank = $urandom_range(MAX_RANK + 1, MAX_RANK + 4);
            else
                rank = $urandom_range(1, MAX_RANK);
            flags = '0;
            if (kind < 75) begin
                len = $urandom_range(0, rank);
                start = $urandom_range(0, rank - len);
                for (int i = 0; i < len; i++)
                    flags[start + i] = 1'b1;
            end else begin
                flags = (MAX_RANK + 4)'($urandom);
            end
            contig = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < rank; i++)
                add_dim(pick_size(), flags[i], i == rank - 1,
                        (i == rank - 1) ? contig : 1'($urandom_range(0, 1)));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (dims_pending.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_layouts.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS tensor_reduction_layout_classifier_unit");
        end else begin
            $display("FAIL tensor_reduction_layout_classifier_unit");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("FAIL tensor_reduction_layout_classifier_unit");
        $finish;
    end

endmodule
